### hw/rtl/vurp_pkg.sv
// Shared types and constants for the video unit register port.
package vurp_pkg;

  localparam int unsigned PATTERN_BYTES = 8192;
  localparam int unsigned SPRITE_BYTES  = 256;
  localparam int unsigned PAL_BYTES     = 32;

  localparam logic [13:0] PALETTE_BASE = 14'h3F00;
  localparam logic [13:0] BIG_STEP     = 14'd32;
  localparam logic [13:0] SMALL_STEP   = 14'd1;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_PATLD  = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_SPR_ADDR = 3'd3,
    REG_SPR_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } state_e;

  typedef struct packed {
    logic        re;
    logic        sprite_we;
    logic        name_we;
    logic        pal_we;
    logic        pat_we;
    logic [7:0]  sprite_addr;
    logic [4:0]  pal_addr;
    logic [12:0] pat_addr;
    logic [7:0]  wdata;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] sprite;
    logic [7:0] name;
    logic [7:0] pal;
    logic [7:0] pat;
  } mem_rdata_t;

endpackage

### hw/rtl/video_unit_register_port_unit.sv
// Top level of the video unit register port: register file, sequencer, output register.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------------------------------
//   in      | in        | in_valid_i / in_stall_o | kind_i reg_sel_i wdata_i pattern_addr_i
//           |           |                         | status_flags_i
//   out     | out       | out_valid_o/out_stall_i | rdata_o
//
// The accept cycle issues the memory reads; the next cycle, in the exec state, modifies,
// writes back and loads the output register, as the memory reads are registered.
// After reset a clearing pass zeroes the sprite, nametable and palette memories, walking every
// nametable address; no item is accepted during it or while an item is in the exec state.
// A stalled output holds the exec state until the output register can take the new item.
module video_unit_register_port_unit #(
  parameter int NAME_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [2:0]  reg_sel_i,
  input  logic [7:0]  wdata_i,
  input  logic [12:0] pattern_addr_i,
  input  logic [2:0]  status_flags_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  rdata_o
);

  localparam int NAME_W = $clog2(NAME_BYTES);
  localparam logic [13:0] ONE_N = 14'(NAME_BYTES);
  localparam logic [13:0] TWO_N = 14'(2 * NAME_BYTES);
  localparam logic [NAME_W-1:0] CLR_LAST = NAME_W'(NAME_BYTES - 1);

  vurp_pkg::state_e state_q, state_d;
  logic [NAME_W-1:0] clr_q, clr_d;

  logic [7:0]  ctrl_q, ctrl_d;
  logic [7:0]  mask_q, mask_d;
  logic [2:0]  status_q, status_d;
  logic [7:0]  sprite_ptr_q, sprite_ptr_d;
  logic [13:0] vram_ptr_q, vram_ptr_d;
  logic [7:0]  rbuf_q, rbuf_d;
  logic        high_next_q, high_next_d;

  vurp_pkg::kind_e kind_q;
  vurp_pkg::reg_e  sel_q;
  logic [7:0]      wdata_q;
  logic [12:0]     paddr_q;
  logic [2:0]      flags_q;
  logic            item_ld;

  logic       out_valid_q, out_valid_d;
  logic [7:0] rdata_q, rdata_d;

  vurp_pkg::mem_req_t   req;
  vurp_pkg::mem_rdata_t mrd;
  logic [NAME_W-1:0]    name_addr;

  logic [13:0]       name_off, name_off1, name_off2;
  logic [NAME_W-1:0] name_idx;
  logic [4:0]        pal_slot;
  logic              is_pat, is_pal;
  logic [7:0]        bus_val;
  logic [13:0]       vram_step;
  logic [7:0]        r;

  always_comb begin
    name_off  = {1'b0, vram_ptr_q[12:0]};
    name_off1 = (name_off >= TWO_N) ? (name_off - TWO_N) : name_off;
    name_off2 = (name_off1 >= ONE_N) ? (name_off1 - ONE_N) : name_off1;
    name_idx  = name_off2[NAME_W-1:0];
    pal_slot  = {vram_ptr_q[4] & (vram_ptr_q[1:0] != 2'b00), vram_ptr_q[3:0]};
    is_pat    = !vram_ptr_q[13];
    is_pal    = (vram_ptr_q >= vurp_pkg::PALETTE_BASE);
    if (is_pat) begin
      bus_val = mrd.pat;
    end else if (is_pal) begin
      bus_val = mrd.pal;
    end else begin
      bus_val = mrd.name;
    end
    vram_step = vram_ptr_q + (ctrl_q[2] ? vurp_pkg::BIG_STEP : vurp_pkg::SMALL_STEP);
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    in_stall_o   = 1'b1;
    item_ld      = 1'b0;
    ctrl_d       = ctrl_q;
    mask_d       = mask_q;
    status_d     = status_q;
    sprite_ptr_d = sprite_ptr_q;
    vram_ptr_d   = vram_ptr_q;
    rbuf_d       = rbuf_q;
    high_next_d  = high_next_q;
    out_valid_d  = out_valid_q & out_stall_i;
    rdata_d      = rdata_q;
    r            = 8'd0;
    name_addr    = name_idx;
    req             = '0;
    req.sprite_addr = sprite_ptr_q;
    req.pal_addr    = pal_slot;
    req.pat_addr    = vram_ptr_q[12:0];
    req.wdata       = wdata_q;
    case (state_q)
      vurp_pkg::ST_CLEAR: begin
        req.sprite_we   = 1'b1;
        req.name_we     = 1'b1;
        req.pal_we      = 1'b1;
        req.sprite_addr = clr_q[7:0];
        req.pal_addr    = clr_q[4:0];
        req.wdata       = 8'd0;
        name_addr       = clr_q;
        clr_d           = clr_q + 1'b1;
        if (clr_q == CLR_LAST) begin
          state_d = vurp_pkg::ST_IDLE;
        end
      end
      vurp_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          req.re  = 1'b1;
          item_ld = 1'b1;
          state_d = vurp_pkg::ST_EXEC;
        end
      end
      vurp_pkg::ST_EXEC: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = vurp_pkg::ST_IDLE;
          case (kind_q)
            vurp_pkg::KIND_READ: begin
              case (sel_q)
                vurp_pkg::REG_STATUS: begin
                  r           = {status_q, 5'd0};
                  status_d    = {1'b0, status_q[1:0]};
                  high_next_d = 1'b1;
                end
                vurp_pkg::REG_SPR_DATA: r = mrd.sprite;
                vurp_pkg::REG_DATA: begin
                  r          = is_pal ? bus_val : rbuf_q;
                  rbuf_d     = bus_val;
                  vram_ptr_d = vram_step;
                end
                default: r = 8'd0;
              endcase
            end
            vurp_pkg::KIND_WRITE: begin
              case (sel_q)
                vurp_pkg::REG_CTRL:     ctrl_d = wdata_q;
                vurp_pkg::REG_MASK:     mask_d = wdata_q;
                vurp_pkg::REG_SPR_ADDR: sprite_ptr_d = wdata_q;
                vurp_pkg::REG_SPR_DATA: begin
                  req.sprite_we = 1'b1;
                  sprite_ptr_d  = sprite_ptr_q + 8'd1;
                end
                vurp_pkg::REG_ADDR: begin
                  if (high_next_q) begin
                    vram_ptr_d = {wdata_q[5:0], vram_ptr_q[7:0]};
                  end else begin
                    vram_ptr_d = {vram_ptr_q[13:8], wdata_q};
                  end
                  high_next_d = !high_next_q;
                end
                vurp_pkg::REG_DATA: begin
                  req.name_we = !is_pat && !is_pal;
                  req.pal_we  = is_pal;
                  vram_ptr_d  = vram_step;
                end
                default: ;
              endcase
            end
            vurp_pkg::KIND_PATLD: begin
              req.pat_we   = 1'b1;
              req.pat_addr = paddr_q;
            end
            vurp_pkg::KIND_STATUS: status_d = flags_q;
            default: ;
          endcase
          out_valid_d = 1'b1;
          rdata_d     = r;
        end
      end
      default: state_d = vurp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= vurp_pkg::ST_CLEAR;
      clr_q        <= '0;
      ctrl_q       <= 8'd0;
      mask_q       <= 8'd0;
      status_q     <= 3'd0;
      sprite_ptr_q <= 8'd0;
      vram_ptr_q   <= 14'd0;
      rbuf_q       <= 8'd0;
      high_next_q  <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      ctrl_q       <= ctrl_d;
      mask_q       <= mask_d;
      status_q     <= status_d;
      sprite_ptr_q <= sprite_ptr_d;
      vram_ptr_q   <= vram_ptr_d;
      rbuf_q       <= rbuf_d;
      high_next_q  <= high_next_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= rdata_d;
    if (item_ld) begin
      kind_q  <= vurp_pkg::kind_e'(kind_i);
      sel_q   <= vurp_pkg::reg_e'(reg_sel_i);
      wdata_q <= wdata_i;
      paddr_q <= pattern_addr_i;
      flags_q <= status_flags_i;
    end
  end

  vurp_mem #(
    .NAME_BYTES(NAME_BYTES)
  ) u_mem (
    .clk_i      (clk_i),
    .req_i      (req),
    .name_addr_i(name_addr),
    .rdata_o    (mrd)
  );

  assign out_valid_o = out_valid_q;
  assign rdata_o     = rdata_q;

endmodule

### hw/rtl/vurp_mem.sv
// Sprite, nametable, palette and pattern memories with registered reads.
module vurp_mem #(
  parameter int NAME_BYTES = 2048,
  localparam int NAME_W = $clog2(NAME_BYTES)
) (
  input  logic                  clk_i,
  input  vurp_pkg::mem_req_t    req_i,
  input  logic [NAME_W-1:0]     name_addr_i,
  output vurp_pkg::mem_rdata_t  rdata_o
);

  logic [7:0] sprite_mem [vurp_pkg::SPRITE_BYTES];
  logic [7:0] name_mem   [NAME_BYTES];
  logic [7:0] pal_mem    [vurp_pkg::PAL_BYTES];
  logic [7:0] pat_mem    [vurp_pkg::PATTERN_BYTES];

  vurp_pkg::mem_rdata_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.sprite_we) begin
      sprite_mem[req_i.sprite_addr] <= req_i.wdata;
    end
    if (req_i.name_we) begin
      name_mem[name_addr_i] <= req_i.wdata;
    end
    if (req_i.pal_we) begin
      pal_mem[req_i.pal_addr] <= req_i.wdata;
    end
    if (req_i.pat_we) begin
      pat_mem[req_i.pat_addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q.sprite <= sprite_mem[req_i.sprite_addr];
      rdata_q.name   <= name_mem[name_addr_i];
      rdata_q.pal    <= pal_mem[req_i.pal_addr];
      rdata_q.pat    <= pat_mem[req_i.pat_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
